// ===== hdl/tsw_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tsw_pkg
// Shared types, codes and reset table for the TDMA slot wheel scheduler.
// ---------------------------------------------------------------------------
package tsw_pkg;

  localparam int SLOT_COUNT_DEF  = 16;
  localparam int EVENT_DEPTH_DEF = 1024;

  localparam logic [15:0] SYNC_PERIOD_RST = 16'd1000;
  localparam logic [1:0]  INITIAL_SYNCS   = 2'd3;
  localparam logic [7:0]  RESET_ENTRIES   = 8'd10;

  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 16;
  localparam int OBUF_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_POP   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ACT_NONE          = 3'd0,
    ACT_RX_START      = 3'd1,
    ACT_RX_STOP       = 3'd2,
    ACT_TX_START      = 3'd3,
    ACT_TX_STOP       = 3'd4,
    ACT_RX_STOP_TX_ST = 3'd5,
    ACT_TX_STOP_RX_ST = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_RX   = 2'd1,
    MODE_TX   = 2'd2,
    MODE_SYNC = 2'd3
  } mode_t;

  localparam logic EV_RX_START = 1'b0;
  localparam logic EV_TX_START = 1'b1;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] fire_time;
  } slot_entry_t;

  // Packed result item, sync_request in bit 0.
  typedef struct packed {
    logic       queue_overflow;
    logic       event_code;
    logic       event_valid;
    logic [3:0] current_slot;
    logic [1:0] mode;
    logic       tx_on;
    logic       rx_on;
    logic [2:0] fired_action;
    logic       action_fired;
    logic       sync_request;
  } out_item_t;

  // Power-up contents of a slot entry.
  function automatic slot_entry_t slot_reset_entry(input logic [7:0] idx);
    slot_entry_t e;
    e.fire_time = 8'd0;
    e.action    = ACT_NONE;
    if (idx < RESET_ENTRIES) begin
      e.fire_time = idx + 8'd1;
      e.action    = idx[0] ? ACT_RX_START : ACT_TX_START;
    end
    return e;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/tdma_slot_wheel_scheduler.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tdma_slot_wheel_scheduler
// Slot wheel stepped by timer ticks, with slot table writes and event pops.
// ---------------------------------------------------------------------------
// Takes one item per clock while in_tready is high. Each item produces one
// result item; it passes the slot table read, then the action, event queue
// access and event memory read, then the output buffer. Results wait in a
// 4-entry output buffer; in_tready drops only when four items are in flight
// or buffered. The slot table (one read per item, one write per slot write)
// and the event queue memory (one access per item) hold the wheel state;
// slot entries not yet written read as their power-up values. cfg_ready
// is always high; write sync_period only while idle.
// ---------------------------------------------------------------------------
module tdma_slot_wheel_scheduler #(
  parameter int SLOT_COUNT  = tsw_pkg::SLOT_COUNT_DEF,
  parameter int EVENT_DEPTH = tsw_pkg::EVENT_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input item
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // [3:0] entry_index, [11:4] entry_time, [14:12] entry_action, [15] zero
  input  wire logic [tsw_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] kind
  input  wire logic [tsw_pkg::IN_USER_W-1:0]  in_tuser,
  // result item
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // [0] sync_request, [1] action_fired, [4:2] fired_action, [5] rx_on,
  // [6] tx_on, [8:7] mode, [12:9] current_slot, [13] event_valid,
  // [14] event_code, [15] queue_overflow
  output logic [tsw_pkg::OUT_DATA_W-1:0]      out_tdata,
  // sync_period write
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [15:0]                    cfg_data
);

  localparam int PTR_W  = $clog2(SLOT_COUNT);
  localparam int EV_AW  = $clog2(EVENT_DEPTH);
  localparam int EV_CW  = $clog2(EVENT_DEPTH + 1);
  localparam int OB_AW  = $clog2(tsw_pkg::OBUF_DEPTH);
  localparam int OB_CW  = $clog2(tsw_pkg::OBUF_DEPTH + 1);

  // ---------------- input decode ----------------
  logic       in_acc;
  logic [1:0] in_kind;
  logic [3:0] in_idx;
  logic [7:0] in_time;
  logic [2:0] in_act;
  logic       in_idx_ok;

  assign in_acc    = in_tvalid && in_tready;
  assign in_kind   = in_tuser[1:0];
  assign in_idx    = in_tdata[3:0];
  assign in_time   = in_tdata[11:4];
  assign in_act    = in_tdata[14:12];
  assign in_idx_ok = 10'(in_idx) < 10'(SLOT_COUNT);

  // ---------------- configuration ----------------
  logic [15:0] sync_period_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_period_r <= tsw_pkg::SYNC_PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      sync_period_r <= cfg_data;
    end
  end

  // ---------------- stage 0: counters, slot table access ----------------
  logic [15:0]      sync_cnt_r, sync_cnt_nxt;
  logic [1:0]       init_syncs_r, init_syncs_nxt;
  logic [7:0]       wheel_r, wheel_nxt, wheel_inc;
  logic [PTR_W-1:0] ptr_r, ptr_nxt, ptr_inc;
  logic [15:0]      sync_cnt_inc;
  logic             tick_sync;

  always_comb begin
    sync_cnt_inc   = sync_cnt_r + 16'd1;
    wheel_inc      = wheel_r + 8'd1;
    ptr_inc        = (ptr_r == PTR_W'(SLOT_COUNT - 1)) ? '0 : ptr_r + PTR_W'(1);
    tick_sync      = (init_syncs_r < tsw_pkg::INITIAL_SYNCS) ||
                     (sync_cnt_inc >= sync_period_r);
    sync_cnt_nxt   = sync_cnt_r;
    init_syncs_nxt = init_syncs_r;
    wheel_nxt      = wheel_r;
    ptr_nxt        = ptr_r;
    if (in_acc && in_kind == tsw_pkg::KIND_TICK) begin
      if (tick_sync) begin
        sync_cnt_nxt = '0;
        if (init_syncs_r < tsw_pkg::INITIAL_SYNCS) begin
          init_syncs_nxt = init_syncs_r + 2'd1;
        end
      end else begin
        sync_cnt_nxt = sync_cnt_inc;
        ptr_nxt      = ptr_inc;
        wheel_nxt    = (ptr_inc == '0) ? 8'd0 : wheel_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_cnt_r   <= '0;
      init_syncs_r <= '0;
      wheel_r      <= '0;
      ptr_r        <= '0;
    end else begin
      sync_cnt_r   <= sync_cnt_nxt;
      init_syncs_r <= init_syncs_nxt;
      wheel_r      <= wheel_nxt;
      ptr_r        <= ptr_nxt;
    end
  end

  // slot table memory, valid bit per entry
  tsw_pkg::slot_entry_t slot_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] slot_vld_r;
  tsw_pkg::slot_entry_t slot_rd_r;
  logic                  slot_rd_vld_r;
  logic                  slot_we;

  assign slot_we = in_acc && in_kind == tsw_pkg::KIND_WRITE && in_idx_ok;

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[PTR_W'(in_idx)] <= {in_act, in_time};
    end
    if (in_acc) begin
      slot_rd_r     <= slot_mem[ptr_r];
      slot_rd_vld_r <= slot_vld_r[ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r <= '0;
    end else if (slot_we) begin
      slot_vld_r[PTR_W'(in_idx)] <= 1'b1;
    end
  end

  // stage 1 pipeline registers
  logic             s1_vld_r;
  logic [1:0]       s1_kind_r;
  logic             s1_sync_r;
  logic [7:0]       s1_wheel_r;
  logic [PTR_W-1:0] s1_rptr_r;
  logic [PTR_W-1:0] s1_slot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r  <= in_kind;
      s1_sync_r  <= tick_sync;
      s1_wheel_r <= wheel_inc;
      s1_rptr_r  <= ptr_r;
      s1_slot_r  <= ptr_nxt;
    end
  end

  // ---------------- stage 1: action, event queue ----------------
  tsw_pkg::slot_entry_t s1_entry;
  logic                 s1_tick, s1_step, s1_fire;
  logic                 rx_r, rx_nxt, tx_r, tx_nxt;
  logic [1:0]           mode_r, mode_nxt;
  logic                 push, push_code;
  logic                 pop;
  logic                 ev_full, ev_empty;
  logic [EV_AW-1:0]     ev_rp_r, ev_rp_nxt, ev_rp_inc;
  logic [EV_AW-1:0]     ev_wp_r, ev_wp_nxt, ev_wp_inc;
  logic [EV_CW-1:0]     ev_cnt_r, ev_cnt_nxt;
  logic                 s1_ovf;

  always_comb begin
    s1_entry  = slot_rd_vld_r ? slot_rd_r : tsw_pkg::slot_reset_entry(8'(s1_rptr_r));
    s1_tick   = s1_vld_r && s1_kind_r == tsw_pkg::KIND_TICK;
    s1_step   = s1_tick && !s1_sync_r;
    s1_fire   = s1_step && (s1_wheel_r == s1_entry.fire_time);
    rx_nxt    = rx_r;
    tx_nxt    = tx_r;
    mode_nxt  = mode_r;
    push      = 1'b0;
    push_code = tsw_pkg::EV_RX_START;
    if (s1_tick && s1_sync_r) begin
      mode_nxt = tsw_pkg::MODE_SYNC;
    end
    if (s1_fire) begin
      unique case (s1_entry.action)
        tsw_pkg::ACT_RX_START: begin
          rx_nxt = 1'b1; mode_nxt = tsw_pkg::MODE_RX;
          push = 1'b1; push_code = tsw_pkg::EV_RX_START;
        end
        tsw_pkg::ACT_RX_STOP: begin
          rx_nxt = 1'b0; mode_nxt = tsw_pkg::MODE_IDLE;
        end
        tsw_pkg::ACT_TX_START: begin
          tx_nxt = 1'b1; mode_nxt = tsw_pkg::MODE_TX;
          push = 1'b1; push_code = tsw_pkg::EV_TX_START;
        end
        tsw_pkg::ACT_TX_STOP: begin
          tx_nxt = 1'b0; mode_nxt = tsw_pkg::MODE_IDLE;
        end
        tsw_pkg::ACT_RX_STOP_TX_ST: begin
          rx_nxt = 1'b0; tx_nxt = 1'b1;
          push = 1'b1; push_code = tsw_pkg::EV_TX_START;
        end
        tsw_pkg::ACT_TX_STOP_RX_ST: begin
          tx_nxt = 1'b0; rx_nxt = 1'b1;
          push = 1'b1; push_code = tsw_pkg::EV_RX_START;
        end
        default: begin
        end
      endcase
    end

    ev_full   = ev_cnt_r == EV_CW'(EVENT_DEPTH);
    ev_empty  = ev_cnt_r == '0;
    ev_rp_inc = (ev_rp_r == EV_AW'(EVENT_DEPTH - 1)) ? '0 : ev_rp_r + EV_AW'(1);
    ev_wp_inc = (ev_wp_r == EV_AW'(EVENT_DEPTH - 1)) ? '0 : ev_wp_r + EV_AW'(1);
    pop       = s1_vld_r && s1_kind_r == tsw_pkg::KIND_POP && !ev_empty;
    s1_ovf    = push && ev_full;
    ev_rp_nxt = ev_rp_r;
    ev_wp_nxt = ev_wp_r;
    ev_cnt_nxt = ev_cnt_r;
    if (push) begin
      ev_wp_nxt = ev_wp_inc;
      if (ev_full) begin
        ev_rp_nxt = ev_rp_inc;
      end else begin
        ev_cnt_nxt = ev_cnt_r + EV_CW'(1);
      end
    end else if (pop) begin
      ev_rp_nxt  = ev_rp_inc;
      ev_cnt_nxt = ev_cnt_r - EV_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_r     <= 1'b0;
      tx_r     <= 1'b0;
      mode_r   <= tsw_pkg::MODE_IDLE;
      ev_rp_r  <= '0;
      ev_wp_r  <= '0;
      ev_cnt_r <= '0;
    end else begin
      rx_r     <= rx_nxt;
      tx_r     <= tx_nxt;
      mode_r   <= mode_nxt;
      ev_rp_r  <= ev_rp_nxt;
      ev_wp_r  <= ev_wp_nxt;
      ev_cnt_r <= ev_cnt_nxt;
    end
  end

  // event queue memory
  logic ev_mem [EVENT_DEPTH];
  logic ev_rd_r;

  always_ff @(posedge clk) begin
    if (push) begin
      ev_mem[ev_wp_r] <= push_code;
    end
    if (pop) begin
      ev_rd_r <= ev_mem[ev_rp_r];
    end
  end

  // stage 2 registers
  logic       s2_vld_r;
  tsw_pkg::out_item_t s2_item_r, s2_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      s2_item_r.sync_request   <= s1_tick && s1_sync_r;
      s2_item_r.action_fired   <= s1_fire;
      s2_item_r.fired_action   <= s1_fire ? s1_entry.action : 3'd0;
      s2_item_r.rx_on          <= rx_nxt;
      s2_item_r.tx_on          <= tx_nxt;
      s2_item_r.mode           <= mode_nxt;
      s2_item_r.current_slot   <= 4'(s1_slot_r);
      s2_item_r.event_valid    <= pop;
      s2_item_r.event_code     <= 1'b0;
      s2_item_r.queue_overflow <= s1_ovf;
    end
  end

  always_comb begin
    s2_item            = s2_item_r;
    s2_item.event_code = s2_item_r.event_valid && ev_rd_r;
  end

  // ---------------- output buffer and credits ----------------
  tsw_pkg::out_item_t obuf [tsw_pkg::OBUF_DEPTH];
  logic [OB_AW-1:0] ob_head_r, ob_tail_r;
  logic [OB_CW-1:0] ob_cnt_r, ob_cnt_nxt;
  logic [OB_CW-1:0] credit_r, credit_nxt;
  logic             out_acc;

  assign out_acc    = out_tvalid && out_tready;
  assign out_tvalid = ob_cnt_r != '0;
  assign out_tdata  = obuf[ob_head_r];
  assign in_tready  = credit_r != OB_CW'(tsw_pkg::OBUF_DEPTH);

  always_comb begin
    ob_cnt_nxt = ob_cnt_r;
    credit_nxt = credit_r;
    if (s2_vld_r && !out_acc) begin
      ob_cnt_nxt = ob_cnt_r + OB_CW'(1);
    end else if (!s2_vld_r && out_acc) begin
      ob_cnt_nxt = ob_cnt_r - OB_CW'(1);
    end
    if (in_acc && !out_acc) begin
      credit_nxt = credit_r + OB_CW'(1);
    end else if (!in_acc && out_acc) begin
      credit_nxt = credit_r - OB_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_vld_r) begin
      obuf[ob_tail_r] <= s2_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_head_r <= '0;
      ob_tail_r <= '0;
      ob_cnt_r  <= '0;
      credit_r  <= '0;
    end else begin
      ob_cnt_r <= ob_cnt_nxt;
      credit_r <= credit_nxt;
      if (s2_vld_r) begin
        ob_tail_r <= ob_tail_r + OB_AW'(1);
      end
      if (out_acc) begin
        ob_head_r <= ob_head_r + OB_AW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== bench/tdma_slot_wheel_scheduler_checker.sv =====
// ---------------------------------------------------------------------------
// tdma_slot_wheel_scheduler_checker
// Watches the item, result and sync_period channels of the slot wheel
// scheduler. It keeps its own copy of the wheel, slot table and event queue,
// works out the status item due for every accepted input item, and compares
// each result item field by field with the oldest one still due.
// ---------------------------------------------------------------------------
module tdma_slot_wheel_scheduler_checker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  input  wire logic                           in_tready,
  // [3:0] entry_index, [11:4] entry_time, [14:12] entry_action, [15] zero
  input  wire logic [tsw_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] kind
  input  wire logic [tsw_pkg::IN_USER_W-1:0]  in_tuser,
  input  wire logic                           out_tvalid,
  input  wire logic                           out_tready,
  // [0] sync_request, [1] action_fired, [4:2] fired_action, [5] rx_on,
  // [6] tx_on, [8:7] mode, [12:9] current_slot, [13] event_valid,
  // [14] event_code, [15] queue_overflow
  input  wire logic [tsw_pkg::OUT_DATA_W-1:0] out_tdata,
  input  wire logic                           cfg_valid,
  input  wire logic                           cfg_ready,
  input  wire logic [15:0]                    cfg_data,
  output int                                  mismatches,
  output int                                  outstanding
);

  localparam int SLOTS  = tsw_pkg::SLOT_COUNT_DEF;
  localparam int QDEPTH = tsw_pkg::EVENT_DEPTH_DEF;

  logic [15:0]        period;
  logic [7:0]         slot_fire_time [SLOTS];
  logic [2:0]         slot_act [SLOTS];
  logic [7:0]         wheel;
  logic [3:0]         slot_ptr;
  logic [15:0]        sync_cnt;
  logic [1:0]         syncs_done;
  logic               rx_q;
  logic               tx_q;
  tsw_pkg::mode_t     mode_q;
  logic               event_mem [QDEPTH];
  logic [9:0]         ev_rd;
  logic [9:0]         ev_wr;
  int                 ev_count;
  tsw_pkg::out_item_t expected_status [$];

  task automatic push_event(input logic code, output logic lost);
    lost = 1'b0;
    if (ev_count >= QDEPTH) begin
      lost     = 1'b1;
      ev_rd    = ev_rd + 1'b1;
      ev_count = QDEPTH - 1;
    end
    event_mem[ev_wr] = code;
    ev_wr    = ev_wr + 1'b1;
    ev_count = ev_count + 1;
  endtask

  task automatic step_wheel(input logic [1:0] kind, input logic [3:0] idx,
                            input logic [7:0] tm, input logic [2:0] act,
                            output tsw_pkg::out_item_t res);
    logic [3:0] p;
    logic       lost;
    res  = '0;
    lost = 1'b0;
    case (kind)
      tsw_pkg::KIND_TICK: begin
        sync_cnt = sync_cnt + 1'b1;
        if (syncs_done < tsw_pkg::INITIAL_SYNCS || sync_cnt >= period) begin
          res.sync_request = 1'b1;
          mode_q   = tsw_pkg::MODE_SYNC;
          sync_cnt = '0;
          if (syncs_done < tsw_pkg::INITIAL_SYNCS) syncs_done = syncs_done + 1'b1;
        end else begin
          p     = slot_ptr;
          wheel = wheel + 1'b1;
          if (wheel == slot_fire_time[p]) begin
            res.action_fired = 1'b1;
            res.fired_action = slot_act[p];
            case (slot_act[p])
              tsw_pkg::ACT_RX_START: begin
                rx_q   = 1'b1;
                mode_q = tsw_pkg::MODE_RX;
                push_event(tsw_pkg::EV_RX_START, lost);
              end
              tsw_pkg::ACT_RX_STOP: begin
                rx_q   = 1'b0;
                mode_q = tsw_pkg::MODE_IDLE;
              end
              tsw_pkg::ACT_TX_START: begin
                tx_q   = 1'b1;
                mode_q = tsw_pkg::MODE_TX;
                push_event(tsw_pkg::EV_TX_START, lost);
              end
              tsw_pkg::ACT_TX_STOP: begin
                tx_q   = 1'b0;
                mode_q = tsw_pkg::MODE_IDLE;
              end
              tsw_pkg::ACT_RX_STOP_TX_ST: begin
                rx_q = 1'b0;
                tx_q = 1'b1;
                push_event(tsw_pkg::EV_TX_START, lost);
              end
              tsw_pkg::ACT_TX_STOP_RX_ST: begin
                tx_q = 1'b0;
                rx_q = 1'b1;
                push_event(tsw_pkg::EV_RX_START, lost);
              end
              default: ;
            endcase
          end
          slot_ptr = p + 1'b1;
          if (slot_ptr == '0) wheel = '0;
        end
      end
      tsw_pkg::KIND_WRITE: begin
        slot_fire_time[idx] = tm;
        slot_act[idx]       = act;
      end
      tsw_pkg::KIND_POP: begin
        if (ev_count > 0) begin
          res.event_valid = 1'b1;
          res.event_code  = event_mem[ev_rd];
          ev_rd    = ev_rd + 1'b1;
          ev_count = ev_count - 1;
        end
      end
      default: ;
    endcase
    res.queue_overflow = lost;
    res.rx_on          = rx_q;
    res.tx_on          = tx_q;
    res.mode           = mode_q;
    res.current_slot   = slot_ptr;
  endtask

  task automatic check(input string name, input int unsigned want,
                       input int unsigned got);
    if (want != got) begin
      mismatches = mismatches + 1;
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    tsw_pkg::out_item_t got;
    tsw_pkg::out_item_t want;
    tsw_pkg::out_item_t res;
    if (!rst_n) begin
      period = tsw_pkg::SYNC_PERIOD_RST;
      for (int i = 0; i < SLOTS; i++) begin
        if (i < tsw_pkg::RESET_ENTRIES) begin
          slot_fire_time[i] = 8'(i + 1);
          slot_act[i]       = (i % 2 == 1) ? tsw_pkg::ACT_RX_START : tsw_pkg::ACT_TX_START;
        end else begin
          slot_fire_time[i] = '0;
          slot_act[i]       = tsw_pkg::ACT_NONE;
        end
      end
      wheel      = '0;
      slot_ptr   = '0;
      sync_cnt   = '0;
      syncs_done = '0;
      rx_q       = 1'b0;
      tx_q       = 1'b0;
      mode_q     = tsw_pkg::MODE_IDLE;
      ev_rd      = '0;
      ev_wr      = '0;
      ev_count   = 0;
      expected_status.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) period = cfg_data;
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_status.size() == 0) begin
          mismatches = mismatches + 1;
          $display("%0t: result item expected none, actual %h", $time, out_tdata);
        end else begin
          want = expected_status.pop_front();
          check("sync_request", want.sync_request, got.sync_request);
          check("action_fired", want.action_fired, got.action_fired);
          check("fired_action", want.fired_action, got.fired_action);
          check("rx_on", want.rx_on, got.rx_on);
          check("tx_on", want.tx_on, got.tx_on);
          check("mode", want.mode, got.mode);
          check("current_slot", want.current_slot, got.current_slot);
          check("event_valid", want.event_valid, got.event_valid);
          check("event_code", want.event_code, got.event_code);
          check("queue_overflow", want.queue_overflow, got.queue_overflow);
        end
      end
      if (in_tvalid && in_tready) begin
        step_wheel(in_tuser, in_tdata[3:0], in_tdata[11:4], in_tdata[14:12], res);
        expected_status.push_back(res);
      end
    end
    outstanding = expected_status.size();
  end

endmodule

// ===== bench/tdma_slot_wheel_scheduler_tb.sv =====
// ---------------------------------------------------------------------------
// tdma_slot_wheel_scheduler_tb
// Drives the slot wheel scheduler with ticks, slot table writes and event
// pops: a directed opening, random phases under several sync periods, and a
// tick-heavy phase that fills the event queue past overflow while the result
// side holds off. The checker instance predicts and compares every result.
// ---------------------------------------------------------------------------
module tdma_slot_wheel_scheduler_tb;

  localparam logic [1:0] KIND_SPARE  = 2'd3;
  localparam logic [2:0] ACT_SPARE   = 3'd7;
  localparam int         HOLD_CYCLES = 80;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [tsw_pkg::IN_DATA_W-1:0]  in_tdata;
  logic [tsw_pkg::IN_USER_W-1:0]  in_tuser;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [tsw_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [15:0]                    cfg_data;
  int                             mismatches;
  int                             outstanding;
  logic                           steady;
  logic                           hold_go;
  logic                           hold_done;

  tdma_slot_wheel_scheduler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  tdma_slot_wheel_scheduler_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("tdma_slot_wheel_scheduler: mismatch");
    $finish;
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    out_tready <= 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      out_tready <= steady || ($urandom_range(99) >= 17);
    end
  end

  task automatic send_item(input logic [1:0] kind, input logic [3:0] idx,
                           input logic [7:0] tm, input logic [2:0] act);
    while (!steady && $urandom_range(99) < 17) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {1'b0, act, tm, idx};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send_noise(input logic [1:0] kind);
    send_item(kind, 4'($urandom), 8'($urandom), 3'($urandom));
  endtask

  task automatic send_random(input int tick_pct);
    int         r;
    logic [7:0] tm;
    r = int'($urandom_range(99));
    // mostly times the wheel can reach
    if ($urandom_range(99) < 80) tm = 8'($urandom_range(16, 1));
    else tm = 8'($urandom_range(255));
    if (r < tick_pct) send_noise(tsw_pkg::KIND_TICK);
    else if (r < tick_pct + 15) send_item(tsw_pkg::KIND_WRITE, 4'($urandom), tm, 3'($urandom));
    else if (r < 98) send_noise(tsw_pkg::KIND_POP);
    else send_noise(KIND_SPARE);
  endtask

  task automatic quiesce();
    in_tvalid <= 1'b0;
    @(negedge clk);
    wait (outstanding == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_period(input logic [15:0] value);
    quiesce();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [15:0] value, input int count,
                           input int tick_pct);
    write_period(value);
    repeat (count) send_random(tick_pct);
  endtask

  initial begin
    logic [2:0] start_act;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= tsw_pkg::KIND_TICK;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    steady  = 1'b0;
    hold_go = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty pop, unused kind, the three initial syncs
    send_item(tsw_pkg::KIND_POP, 4'd0, 8'd0, tsw_pkg::ACT_NONE);
    send_item(KIND_SPARE, 4'hf, 8'hff, ACT_SPARE);
    repeat (3) send_item(tsw_pkg::KIND_TICK, 4'd0, 8'd0, tsw_pkg::ACT_NONE);
    // entries 0..7 fire every action code in turn
    send_item(tsw_pkg::KIND_WRITE, 4'd15, 8'd255, ACT_SPARE);
    for (int i = 0; i < 8; i++) send_item(tsw_pkg::KIND_WRITE, 4'(i), 8'(i + 1), 3'(i));
    repeat (8) send_item(tsw_pkg::KIND_TICK, 4'd0, 8'd0, tsw_pkg::ACT_NONE);
    repeat (3) send_item(tsw_pkg::KIND_POP, 4'd0, 8'd0, tsw_pkg::ACT_NONE);

    run_phase(16'd1, 30, 65);
    run_phase(16'd65535, 40, 60);
    run_phase(16'd0, 20, 65);
    steady = 1'b1;
    run_phase(16'd5, 80, 60);
    steady = 1'b0;
    run_phase(16'd17, 40, 60);
    run_phase(tsw_pkg::SYNC_PERIOD_RST, 30, 55);
    run_phase(16'd2, 30, 60);
    repeat (3) run_phase(16'($urandom_range(40, 3)), 20, 60);

    // every slot fires a start: the event queue fills and overflows
    write_period(16'd65535);
    for (int i = 0; i < 16; i++) begin
      case ($urandom_range(3))
        0: start_act = tsw_pkg::ACT_RX_START;
        1: start_act = tsw_pkg::ACT_TX_START;
        2: start_act = tsw_pkg::ACT_RX_STOP_TX_ST;
        default: start_act = tsw_pkg::ACT_TX_STOP_RX_ST;
      endcase
      send_item(tsw_pkg::KIND_WRITE, 4'(i), 8'(i + 1), start_act);
    end
    for (int i = 0; i < 1100; i++) begin
      if (i == 300) hold_go = 1'b1;
      if ($urandom_range(99) < 99) send_noise(tsw_pkg::KIND_TICK);
      else send_noise(tsw_pkg::KIND_POP);
    end
    repeat (30) send_noise(tsw_pkg::KIND_POP);

    quiesce();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tdma_slot_wheel_scheduler: match");
    end else begin
      $display("tdma_slot_wheel_scheduler: mismatch");
    end
    $finish;
  end

endmodule
